>>> src/wdfc_pkg.sv
// Shared types, constants and the arctangent table for the wind direction pipeline.
package wdfc_pkg;

  localparam int COMP_WIDTH    = 16;
  localparam int VEC_W         = COMP_WIDTH + 11;
  localparam int ACC_W         = 26;
  localparam int FIN_W         = ACC_W + 1;
  localparam int DIR_W         = 16;
  localparam int TABLE_LEN     = 24;
  localparam int DEG_SCALE     = 65536;
  localparam int FULL_TURN_OUT = 46080;
  localparam int HALF_TURN_OUT = 23040;

  localparam logic signed [ACC_W-1:0] ACC_QUARTER = ACC_W'(90 * DEG_SCALE);
  localparam logic signed [FIN_W-1:0] ACC_OFFSET  = FIN_W'(360 * DEG_SCALE + 256);
  localparam logic [DIR_W:0]          TURN_OUT    = (DIR_W + 1)'(FULL_TURN_OUT);
  localparam logic [DIR_W-1:0]        HALF_OUT    = DIR_W'(HALF_TURN_OUT);

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] u_comp;
    logic signed [COMP_WIDTH-1:0] v_comp;
    logic                         u_missing;
    logic                         v_missing;
  } wdfc_req_t;

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic             dir_missing;
  } wdfc_rsp_t;

  typedef struct packed {
    logic                    valid;
    logic                    miss;
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
  } wdfc_stage_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_step(input int i);
    logic signed [ACC_W-1:0] t;
    case (i)
      0:       t = ACC_W'(2949120);
      1:       t = ACC_W'(1740967);
      2:       t = ACC_W'(919879);
      3:       t = ACC_W'(466945);
      4:       t = ACC_W'(234379);
      5:       t = ACC_W'(117304);
      6:       t = ACC_W'(58666);
      7:       t = ACC_W'(29335);
      8:       t = ACC_W'(14668);
      9:       t = ACC_W'(7334);
      10:      t = ACC_W'(3667);
      11:      t = ACC_W'(1833);
      12:      t = ACC_W'(917);
      13:      t = ACC_W'(458);
      14:      t = ACC_W'(229);
      15:      t = ACC_W'(115);
      16:      t = ACC_W'(57);
      17:      t = ACC_W'(29);
      18:      t = ACC_W'(14);
      19:      t = ACC_W'(7);
      20:      t = ACC_W'(4);
      21:      t = ACC_W'(2);
      22:      t = ACC_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> src/wdfc_prerot.sv
// Input stage: scales the components, forms the working vector and folds it into the right half plane.
module wdfc_prerot
  import wdfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        req_valid,
  input  wdfc_req_t   req,
  output wdfc_stage_t stage
);

  wdfc_stage_t stage_next;

  always_comb begin
    logic signed [VEC_W-1:0] ue;
    logic signed [VEC_W-1:0] ve;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    ue = {{(VEC_W-COMP_WIDTH){req.u_comp[COMP_WIDTH-1]}}, req.u_comp};
    ve = {{(VEC_W-COMP_WIDTH){req.v_comp[COMP_WIDTH-1]}}, req.v_comp};
    xs = -(ve <<< 8);
    ys = -(ue <<< 8);
    stage_next.valid = req_valid;
    stage_next.miss  = req.u_missing | req.v_missing;
    stage_next.zero  = (req.u_comp == '0) && (req.v_comp == '0);
    if (xs < 0 && ys >= 0) begin
      stage_next.x   = ys;
      stage_next.y   = -xs;
      stage_next.acc = ACC_QUARTER;
    end else if (xs < 0) begin
      stage_next.x   = -ys;
      stage_next.y   = xs;
      stage_next.acc = -ACC_QUARTER;
    end else begin
      stage_next.x   = xs;
      stage_next.y   = ys;
      stage_next.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

`ifndef ASSERT_OFF
  // After folding, the vector always lies in the right half plane.
  a_right_half: assert property (@(posedge clk) disable iff (rst)
    stage.valid |-> !stage.x[VEC_W-1])
    else $error("prerotated vector has negative x");
`endif

endmodule

>>> src/wdfc_cordic_stage.sv
// One registered vectoring rotation of the arctangent pipeline.
module wdfc_cordic_stage
  import wdfc_pkg::*;
#(
  parameter int STEP = 0
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  wdfc_stage_t prev,
  output wdfc_stage_t stage
);

  localparam logic signed [ACC_W-1:0] ANGLE = atan_step(STEP);

  wdfc_stage_t stage_next;

  always_comb begin
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    dx = prev.y >>> STEP;
    dy = prev.x >>> STEP;
    stage_next = prev;
    if (prev.y > 0) begin
      stage_next.x   = prev.x + dx;
      stage_next.y   = prev.y - dy;
      stage_next.acc = prev.acc + ANGLE;
    end else begin
      stage_next.x   = prev.x - dx;
      stage_next.y   = prev.y + dy;
      stage_next.acc = prev.acc - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

`ifndef ASSERT_OFF
  // The x term never shrinks in vectoring mode, so it stays non-negative.
  a_x_grows: assert property (@(posedge clk) disable iff (rst)
    (en && prev.valid && !prev.x[VEC_W-1]) |=> (stage.x >= $past(prev.x)))
    else $error("vectoring step reduced x");
`endif

endmodule

>>> src/wdfc_finish.sv
// Output stage: offsets and rounds the angle, wraps it into one turn and applies the special cases.
module wdfc_finish
  import wdfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  wdfc_stage_t prev,
  output logic        rsp_valid,
  output wdfc_rsp_t   rsp
);

  wdfc_rsp_t rsp_next;

  always_comb begin
    logic signed [FIN_W-1:0] sum;
    logic [FIN_W-10:0]       q;
    sum = {prev.acc[ACC_W-1], prev.acc} + ACC_OFFSET;
    if (sum < 0) begin
      sum = '0;
    end
    q = sum[FIN_W-1:9];
    // The offset angle stays below two full turns, so one subtraction wraps it.
    if (q[DIR_W:0] >= TURN_OUT) begin
      q = q - (FIN_W-9)'(TURN_OUT);
    end
    if (prev.miss) begin
      rsp_next.direction   = '0;
      rsp_next.dir_missing = 1'b1;
    end else if (prev.zero) begin
      rsp_next.direction   = HALF_OUT;
      rsp_next.dir_missing = 1'b0;
    end else begin
      rsp_next.direction   = q[DIR_W-1:0];
      rsp_next.dir_missing = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= prev.valid;
      rsp       <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_in_turn: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.direction < DIR_W'(FULL_TURN_OUT)))
    else $error("direction outside one turn");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.dir_missing) |-> (rsp.direction == '0))
    else $error("missing result carries a direction");
`endif

endmodule

>>> src/wind_direction_from_components.sv
// An accepted request moves through the fold, rotation and result registers to its result.
// Throughput: one request per cycle unless stalled; one register per rotation sets the depth.
// A result-side stall while a result is valid holds every stage and stalls the request side.
// Reset is synchronous and clears the stage valid bits only; no clearing pass is needed.
// Pipeline: input fold stage, rotation stages, then the rounding and wrap stage.
module wind_direction_from_components
  import wdfc_pkg::*;
#(
  parameter int ANGLE_STEPS = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  wdfc_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output wdfc_rsp_t rsp
);

  localparam int N_ITER = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;

  logic        en;
  wdfc_stage_t stg [N_ITER+1];

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  wdfc_prerot u_prerot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .stage     (stg[0])
  );

  for (genvar k = 0; k < N_ITER; k++) begin : g_rot
    wdfc_cordic_stage #(.STEP(k)) u_rot (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .prev  (stg[k]),
      .stage (stg[k+1])
    );
  end

  wdfc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .prev      (stg[N_ITER]),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> bench/wind_direction_from_components_tb.sv
// Self-checking bench for the wind direction pipeline: directed table, then random requests.
module wind_direction_from_components_tb;
  import wdfc_pkg::*;

  localparam int STEPS      = 16;
  localparam int RAND_REQS  = 1450;

  typedef struct {
    wdfc_req_t req;
    bit        typed;
    wdfc_rsp_t want;
  } req_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  wdfc_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  wdfc_rsp_t rsp;

  req_row_t  request_rows[$];
  wdfc_rsp_t pending_dirs[$];
  int        accepted_reqs;
  int        err_cnt;
  int        phase;
  bit        hold_go;
  int        hold_left;

  wind_direction_from_components #(.ANGLE_STEPS(STEPS)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Rotation angles atan(2^-i) in 1/65536 degree.
  function automatic longint rot_angle(input int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic wdfc_rsp_t predict_direction(input wdfc_req_t r);
    wdfc_rsp_t res;
    longint    u;
    longint    v;
    longint    x;
    longint    y;
    longint    acc;
    longint    t;
    longint    dx;
    longint    dy;
    int        n;
    res.direction   = '0;
    res.dir_missing = 1'b0;
    if (r.u_missing || r.v_missing) begin
      res.dir_missing = 1'b1;
      return res;
    end
    u = $signed(r.u_comp);
    v = $signed(r.v_comp);
    // Calm air reports the south direction.
    if (u == 0 && v == 0) begin
      res.direction = DIR_W'(HALF_TURN_OUT);
      return res;
    end
    x = -v * 256;
    y = -u * 256;
    acc = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        acc = 90 * 65536;
      end else begin
        t = x; x = -y; y = t;
        acc = -90 * 65536;
      end
    end
    n = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; acc = acc + rot_angle(i);
      end else begin
        x = x - dx; y = y + dy; acc = acc - rot_angle(i);
      end
    end
    acc = acc + 360 * 65536 + 256;
    if (acc < 0) acc = 0;
    res.direction = DIR_W'((acc >>> 9) % FULL_TURN_OUT);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic add_row(input int u, input int v, input bit um, input bit vm,
                         input bit typed, input int dir, input bit dm);
    req_row_t row;
    row.req.u_comp          = COMP_WIDTH'(u);
    row.req.v_comp          = COMP_WIDTH'(v);
    row.req.u_missing       = um;
    row.req.v_missing       = vm;
    row.typed               = typed;
    row.want.direction      = DIR_W'(dir);
    row.want.dir_missing    = dm;
    request_rows.push_back(row);
  endtask

  function automatic int pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0:       return -32768;
        1:       return 32767;
        2:       return -1;
        3:       return 1;
        default: return 0;
      endcase
    end
    if (sel < 25) return int'($urandom_range(8)) - 4;
    if (sel < 35) return int'($urandom_range(512)) - 256;
    return int'($signed(16'($urandom)));
  endfunction

  // Scoreboard: queue the typed or predicted result on every accepted request, check every accepted result.
  always @(posedge clk) begin : score
    req_row_t  row;
    wdfc_rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        row = request_rows[accepted_reqs];
        pending_dirs.push_back(row.typed ? row.want : predict_direction(req));
        accepted_reqs++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_dirs.size() == 0) begin
          report_mismatch("unexpected result, direction", rsp.direction, -1);
        end else begin
          want = pending_dirs.pop_front();
          if (rsp.direction !== want.direction)
            report_mismatch("direction", rsp.direction, want.direction);
          if (rsp.dir_missing !== want.dir_missing)
            report_mismatch("dir_missing", rsp.dir_missing, want.dir_missing);
        end
      end
    end
  end

  // Result side: random stalls by phase, plus one long hold-off on request.
  initial begin
    rsp_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (phase)
          0:       rsp_stall <= ($urandom_range(99) < 73);
          1:       rsp_stall <= ($urandom_range(99) < 17);
          default: rsp_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    #(20 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : drive
    int n_directed;
    int total;
    int drain_at;
    int hold_at;
    int idle_pct;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    accepted_reqs = 0;
    err_cnt       = 0;
    phase         = 0;
    hold_go       = 1'b0;

    // Missing flags: the marker wins over any component value.
    add_row(0, 0, 1, 0, 1, 0, 1);
    add_row(0, 0, 0, 1, 1, 0, 1);
    add_row(-32768, 32767, 1, 1, 1, 0, 1);
    add_row(32767, -32768, 1, 0, 1, 0, 1);
    add_row(-1, -1, 0, 1, 1, 0, 1);
    // Calm air.
    add_row(0, 0, 0, 0, 1, HALF_TURN_OUT, 0);
    // Extremes, axes and the quadrant corners go through the predictor.
    add_row(32767, 32767, 0, 0, 0, 0, 0);
    add_row(-32768, -32768, 0, 0, 0, 0, 0);
    add_row(32767, -32768, 0, 0, 0, 0, 0);
    add_row(-32768, 32767, 0, 0, 0, 0, 0);
    add_row(0, 32767, 0, 0, 0, 0, 0);
    add_row(0, -32768, 0, 0, 0, 0, 0);
    add_row(32767, 0, 0, 0, 0, 0, 0);
    add_row(-32768, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 0, 0, 0, 0, 0);
    add_row(-1, 0, 0, 0, 0, 0, 0);
    add_row(0, -1, 0, 0, 0, 0, 0);
    add_row(1, 1, 0, 0, 0, 0, 0);
    add_row(-1, -1, 0, 0, 0, 0, 0);
    add_row(1, -1, 0, 0, 0, 0, 0);
    add_row(-1, 1, 0, 0, 0, 0, 0);
    n_directed = request_rows.size();

    for (int k = 0; k < RAND_REQS; k++)
      add_row(pick_value(), pick_value(), ($urandom_range(99) < 7),
              ($urandom_range(99) < 7), 0, 0, 0);
    total    = request_rows.size();
    drain_at = n_directed + (RAND_REQS / 2);
    hold_at  = n_directed + (RAND_REQS * 5) / 6;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < total; k++) begin
      if (k == n_directed + RAND_REQS / 3) phase = 1;
      if (k == n_directed + (RAND_REQS * 2) / 3) phase = 2;
      if (k == drain_at) begin
        // Let the pipeline empty completely before sending more.
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_dirs.size() != 0) @(negedge clk);
      end
      // The sender keeps offering during this hold-off, so the pipeline fills up.
      if (k == hold_at) hold_go = 1'b1;
      case (phase)
        0:       idle_pct = 17;
        1:       idle_pct = 73;
        default: idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
      req_valid <= 1'b1;
      req       <= request_rows[k].req;
      @(posedge clk);
      while (!(req_valid && !req_stall)) @(posedge clk);
      @(negedge clk);
    end
    req_valid <= 1'b0;

    while (pending_dirs.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
